// ----- rtl/hpti_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hpti_pkg
// shared types and constants of the hashed page table insert block:
// field widths, stream packing, controller states and command/status bundles
// ----------------------------------------------------------------------------
package hpti_pkg;

    localparam int SLOTS_PER_GROUP = 8;
    localparam int SLOT_BITS       = 3;
    localparam int VSID_W          = 24;
    localparam int API_W           = 6;
    localparam int GROUP_OUT_W     = 13;
    localparam int HASH_SRC_W      = 19;
    localparam int ADDR_W          = 32;
    localparam int WORD_W          = 32;
    localparam int IN_DATA_W       = 64;
    localparam int OUT_DATA_W      = 88;

    localparam logic [VSID_W-1:0] VSID_BASE_RESET = 24'h000DC0;
    localparam logic [11:0]       LOWER_FLAGS     = 12'h182;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ_PRI,
        ST_CHECK_PRI,
        ST_READ_SEC,
        ST_CHECK_SEC,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load_in;
        logic calc;
        logic read_row;
        logic check;
        logic sec;
        logic push;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic slot_free;
        logic out_busy;
    } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/hpti_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hpti_ctrl
// controller state machine: clearing pass, item intake, primary and
// secondary group probe, result hand-off
// ----------------------------------------------------------------------------
module hpti_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hpti_pkg::dp_status_t status,
    output hpti_pkg::ctrl_cmd_t     cmd
);
    import hpti_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:      state_next = ST_READ_PRI;
            ST_READ_PRI:  state_next = ST_CHECK_PRI;
            ST_CHECK_PRI: state_next = status.slot_free ? ST_RESULT : ST_READ_SEC;
            ST_READ_SEC:  state_next = ST_CHECK_SEC;
            ST_CHECK_SEC: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:     cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_HASH:      cmd.calc = 1'b1;
            ST_READ_PRI:  cmd.read_row = 1'b1;
            ST_CHECK_PRI: cmd.check = 1'b1;
            ST_READ_SEC:
            begin
                cmd.read_row = 1'b1;
                cmd.sec      = 1'b1;
            end
            ST_CHECK_SEC:
            begin
                cmd.check = 1'b1;
                cmd.sec   = 1'b1;
            end
            ST_RESULT:    cmd.push = !status.out_busy;
            default:      cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/hpti_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hpti_datapath
// segment id and hash registers, group valid-bit memory (one row of eight
// slot bits per group), free slot search and result output register
// ----------------------------------------------------------------------------
module hpti_datapath #(
    parameter int HASH_BITS = 13
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [hpti_pkg::VSID_W-1:0]    cfg_data,
    input  wire logic [hpti_pkg::IN_DATA_W-1:0] in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [hpti_pkg::OUT_DATA_W-1:0]     out_data,
    input  wire hpti_pkg::ctrl_cmd_t            cmd,
    output hpti_pkg::dp_status_t                status
);
    import hpti_pkg::*;

    localparam int GROUPS = 1 << HASH_BITS;

    logic [SLOTS_PER_GROUP-1:0] valid_mem [GROUPS];

    logic [VSID_W-1:0]          vsid_base_reg;
    logic [ADDR_W-1:0]          ea_reg;
    logic [ADDR_W-1:0]          pa_reg;
    logic [VSID_W-1:0]          vsid_reg;
    logic [HASH_BITS-1:0]       hash_reg;
    logic [HASH_BITS-1:0]       clr_cnt_reg;
    logic [SLOTS_PER_GROUP-1:0] row_reg;
    logic                       res_ok_reg;
    logic                       res_sec_reg;
    logic [SLOT_BITS-1:0]       res_slot_reg;
    logic                       out_valid_reg;
    logic [OUT_DATA_W-1:0]      out_data_reg;

    logic [VSID_W-1:0]          vsid_next;
    logic [HASH_SRC_W-1:0]      hash_src;
    logic [HASH_BITS-1:0]       group;
    logic [HASH_BITS-1:0]       res_group;
    logic [SLOT_BITS-1:0]       free_slot;
    logic                       slot_free;
    logic [SLOTS_PER_GROUP-1:0] row_set;
    logic                       mem_we;
    logic [HASH_BITS-1:0]       mem_waddr;
    logic [SLOTS_PER_GROUP-1:0] mem_wdata;
    logic [WORD_W-1:0]          upper_word;
    logic [WORD_W-1:0]          lower_word;

    assign vsid_next = vsid_base_reg + VSID_W'(ea_reg[31:28]);
    assign hash_src  = vsid_next[HASH_SRC_W-1:0] ^ {3'b000, ea_reg[27:12]};
    assign group     = cmd.sec ? ~hash_reg : hash_reg;
    assign res_group = res_sec_reg ? ~hash_reg : hash_reg;

    // first clear valid bit, lowest slot first
    always_comb
    begin
        free_slot = '0;
        for (int i = SLOTS_PER_GROUP - 1; i >= 0; i--)
        begin
            if (!row_reg[i])
            begin
                free_slot = SLOT_BITS'(i);
            end
        end
    end

    assign slot_free = ~&row_reg;

    always_comb
    begin
        for (int i = 0; i < SLOTS_PER_GROUP; i++)
        begin
            row_set[i] = row_reg[i] | (free_slot == SLOT_BITS'(i));
        end
    end

    assign mem_we    = cmd.clear_step | (cmd.check & slot_free);
    assign mem_waddr = cmd.clear_step ? clr_cnt_reg : group;
    assign mem_wdata = cmd.clear_step ? '0 : row_set;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            valid_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read_row)
        begin
            row_reg <= valid_mem[group];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vsid_base_reg <= VSID_BASE_RESET;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                vsid_base_reg <= cfg_data;
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + HASH_BITS'(1);
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ea_reg <= in_data[ADDR_W-1:0];
            pa_reg <= in_data[IN_DATA_W-1:ADDR_W];
        end
        if (cmd.calc)
        begin
            vsid_reg <= vsid_next;
            hash_reg <= hash_src[HASH_BITS-1:0];
        end
        if (cmd.check && (slot_free || cmd.sec))
        begin
            res_ok_reg   <= slot_free;
            res_sec_reg  <= cmd.sec;
            res_slot_reg <= free_slot;
        end
        if (cmd.push)
        begin
            out_data_reg <= res_ok_reg ?
                {6'b000000, lower_word, upper_word, res_slot_reg,
                 GROUP_OUT_W'(res_group), res_sec_reg, 1'b1} : '0;
        end
    end

    assign upper_word = {1'b1, vsid_reg, res_sec_reg, ea_reg[27:22]};
    assign lower_word = {pa_reg[31:12], LOWER_FLAGS};

    assign status.clear_last = &clr_cnt_reg;
    assign status.slot_free  = slot_free;
    assign status.out_busy   = out_valid_reg & ~out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ----- rtl/hashed_page_table_insert_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_page_table_insert_top
// inserts one 4 KB translation per item into a hashed page table: primary
// group probe, then secondary group, first free slot is taken
//
// channel   dir  payload (low bit up)
// s_axis    in   tdata: effective_address[31:0], physical_address[63:32]
// m_axis    out  tdata: inserted, used_secondary, group_index, slot_index,
//                entry_upper_word, entry_lower_word, zero pad
// cfg       in   cfg_data: vsid_base
//
// one item at a time: hash, primary row read and check, then secondary row
// read and check only when the primary group is full, then result hand-off
// after reset a clearing pass over all 2^HASH_BITS groups (8192 by default) keeps
// s_axis_tready low; cfg writes are taken throughout
// a result waiting on m_axis holds only the final hand-off step
// ----------------------------------------------------------------------------
module hashed_page_table_insert_top #(
    parameter int HASH_BITS = 13
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hpti_pkg::VSID_W-1:0]    cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // effective_address, physical_address
    input  wire logic [hpti_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // inserted, used_secondary, group_index, slot_index,
    // entry_upper_word, entry_lower_word
    output logic [hpti_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import hpti_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    hpti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hpti_datapath #(
        .HASH_BITS (HASH_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire

// ----- rtl/hpti_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hpti_checker
// port-level checks of the insert block, bound to the top level
// ----------------------------------------------------------------------------
module hpti_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [hpti_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import hpti_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while busy");

    // full table reports all zero fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata == '0)
        else $error("failed insert with nonzero fields");

    // written entry is valid, carries fixed flag bits and its hash bit matches used_secondary
    a_entry_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            m_axis_tdata[49] && m_axis_tdata[61:50] == LOWER_FLAGS
            && m_axis_tdata[24] == m_axis_tdata[1])
        else $error("malformed entry words");

endmodule

bind hashed_page_table_insert_top hpti_checker u_hpti_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- test/tb_hashed_page_table_insert_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_page_table_insert_top
// drives page table inserts through the stream ports and checks every result
// against a local model of the hashed table: primary and secondary groups,
// first free slot, table full, entry word layout, vsid base changes at idle
// ----------------------------------------------------------------------------
module tb_hashed_page_table_insert_top;

    import hpti_pkg::*;

    localparam int HASH_BITS      = 13;
    localparam int GROUP_COUNT    = 1 << HASH_BITS;
    localparam int ENTRY_COUNT    = GROUP_COUNT * SLOTS_PER_GROUP;
    localparam logic [VSID_W-1:0] VSID_BASE_MAX = 24'd16777200;
    localparam logic [ADDR_W-1:0] PAGE_FLIP     = 32'h01FF_F000;

    typedef struct packed {
        logic                   inserted;
        logic                   used_secondary;
        logic [GROUP_OUT_W-1:0] group_index;
        logic [SLOT_BITS-1:0]   slot_index;
        logic [WORD_W-1:0]      upper_word;
        logic [WORD_W-1:0]      lower_word;
    } pte_result_t;

    function automatic pte_result_t unpack_result(logic [OUT_DATA_W-1:0] data);
        pte_result_t r;
        r.inserted       = data[0];
        r.used_secondary = data[1];
        r.group_index    = data[14:2];
        r.slot_index     = data[17:15];
        r.upper_word     = data[49:18];
        r.lower_word     = data[81:50];
        return r;
    endfunction

    class pte_scoreboard;
        bit                slot_taken [ENTRY_COUNT];
        logic [VSID_W-1:0] vsid_base;
        pte_result_t       expected_q[$];
        int                errors;

        function new();
            vsid_base = VSID_BASE_RESET;
            errors    = 0;
        endfunction

        function void set_base(logic [VSID_W-1:0] value);
            vsid_base = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // probe primary then secondary group, take the first free slot
        function void note_insert(logic [IN_DATA_W-1:0] data);
            logic [ADDR_W-1:0]     ea;
            logic [ADDR_W-1:0]     pa;
            logic [VSID_W-1:0]     vsid;
            logic [HASH_SRC_W-1:0] hash;
            logic [HASH_BITS-1:0]  grp;
            pte_result_t           r;
            bit                    found;
            ea    = data[31:0];
            pa    = data[63:32];
            vsid  = vsid_base + VSID_W'(ea[31:28]);
            hash  = vsid[HASH_SRC_W-1:0] ^ HASH_SRC_W'(ea[27:12]);
            r     = '0;
            found = 1'b0;
            for (int h = 0; h < 2 && !found; h++) begin
                grp = h ? ~hash[HASH_BITS-1:0] : hash[HASH_BITS-1:0];
                for (int s = 0; s < SLOTS_PER_GROUP && !found; s++) begin
                    if (!slot_taken[int'(grp) * SLOTS_PER_GROUP + s]) begin
                        slot_taken[int'(grp) * SLOTS_PER_GROUP + s] = 1'b1;
                        found            = 1'b1;
                        r.inserted       = 1'b1;
                        r.used_secondary = (h != 0);
                        r.group_index    = GROUP_OUT_W'(grp);
                        r.slot_index     = SLOT_BITS'(s);
                        r.upper_word     = {1'b1, vsid, h[0], ea[27:22]};
                        r.lower_word     = {pa[31:12], LOWER_FLAGS};
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        task report(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            $display("%0t: %s mismatch, got %0h, expected %0h", $time, field, got, want);
            errors++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] data);
            pte_result_t got;
            pte_result_t want;
            got = unpack_result(data);
            if (expected_q.size() == 0) begin
                report("unexpected item", got.upper_word, '0);
                return;
            end
            want = expected_q.pop_front();
            if (got.inserted != want.inserted)
                report("inserted", got.inserted, want.inserted);
            if (got.used_secondary != want.used_secondary)
                report("used_secondary", got.used_secondary, want.used_secondary);
            if (got.group_index != want.group_index)
                report("group_index", got.group_index, want.group_index);
            if (got.slot_index != want.slot_index)
                report("slot_index", got.slot_index, want.slot_index);
            if (got.upper_word != want.upper_word)
                report("entry_upper_word", got.upper_word, want.upper_word);
            if (got.lower_word != want.lower_word)
                report("entry_lower_word", got.lower_word, want.lower_word);
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [VSID_W-1:0]      cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    pte_scoreboard pte_sb = new();
    bit            no_idle = 1'b0;
    int            ready_hold = 0;

    hashed_page_table_insert_top #(
        .HASH_BITS(HASH_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                pte_sb.check_result(m_axis_tdata);
                ready_hold = idle_cycles();
            end
            if (s_axis_tvalid && s_axis_tready)
                pte_sb.note_insert(s_axis_tdata);
            if (cfg_valid && cfg_ready)
                pte_sb.set_base(cfg_data);
        end
    end

    always @(negedge clk)
    begin
        if (ready_hold > 0) begin
            m_axis_tready <= 1'b0;
            ready_hold = ready_hold - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_insert(input logic [ADDR_W-1:0] ea, input logic [ADDR_W-1:0] pa);
        int gap;
        gap = idle_cycles();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pa, ea};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic end_stream();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pte_sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_vsid_base(input logic [VSID_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // extremes, then one group pair filled until the table reports full
    task automatic run_directed();
        logic [ADDR_W-1:0] ea;
        ea = 32'h1234_5ABC;
        send_insert(32'h0000_0000, 32'h0000_0000);
        send_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 2 * SLOTS_PER_GROUP + 1; i++)
            send_insert(ea, $urandom);
        // partner address: primary group is the full secondary group
        send_insert(ea ^ PAGE_FLIP, $urandom);
        end_stream();
        wait_drained();
    endtask

    // hot addresses come in complement pairs so groups fill and overflow
    task automatic run_random(input int count);
        logic [ADDR_W-1:0] hot_ea [6];
        for (int i = 0; i < 3; i++) begin
            hot_ea[2 * i]     = $urandom;
            hot_ea[2 * i + 1] = hot_ea[2 * i] ^ PAGE_FLIP;
        end
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 40)
                send_insert($urandom, $urandom);
            else
                send_insert(hot_ea[$urandom_range(0, 5)] ^ ($urandom & 32'hFFF), $urandom);
        end
        end_stream();
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        write_vsid_base('0);
        run_random(150);

        no_idle = 1'b1;
        write_vsid_base(VSID_BASE_MAX);
        run_random(150);
        no_idle = 1'b0;

        write_vsid_base(VSID_W'($urandom_range(0, int'(VSID_BASE_MAX))));
        run_random(150);

        write_vsid_base(VSID_BASE_RESET);
        run_random(130);

        repeat (20) @(posedge clk);
        if (pte_sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
